### hw/rtl/ghnb_pkg.sv
package ghnb_pkg;

    localparam int MAX_SYMBOLS_DEF = 12;
    localparam int COORD_W         = 32;
    localparam int LEN_W           = 4;
    localparam int SLOT_W          = 4;
    localparam int CELL_CODE_W     = 60;
    localparam int S_TDATA_W       = 72;
    localparam int M_TDATA_W       = 72;

    localparam logic [SLOT_W-1:0] SLOT_CENTER = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_N      = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_E      = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_W_     = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_S      = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_NE     = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_NW     = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_SE     = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_SW     = 4'd8;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_INC,
        STEP_DEC
    } step_t;

    typedef struct packed {
        logic              load;
        logic              emit;
        logic [SLOT_W-1:0] slot;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    function automatic step_t lon_step(input logic [SLOT_W-1:0] slot);
        step_t r;
        case (slot) inside
            SLOT_E, SLOT_NE, SLOT_SE:  r = STEP_INC;
            SLOT_W_, SLOT_NW, SLOT_SW: r = STEP_DEC;
            default:                   r = STEP_NONE;
        endcase
        return r;
    endfunction

    function automatic step_t lat_step(input logic [SLOT_W-1:0] slot);
        step_t r;
        case (slot) inside
            SLOT_N, SLOT_NE, SLOT_NW: r = STEP_INC;
            SLOT_S, SLOT_SE, SLOT_SW: r = STEP_DEC;
            default:                  r = STEP_NONE;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/ghnb_ctrl.sv
module ghnb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output ghnb_pkg::dp_cmd_t    cmd,
    input  ghnb_pkg::dp_status_t status
);
    import ghnb_pkg::*;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= SLOT_CENTER;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.slot   = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    slot_next  = SLOT_CENTER;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    slot_next = slot_reg + 1'b1;
                    if (slot_reg == SLOT_SW)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ghnb_dp.sv
module ghnb_dp #(
    parameter int MAX_SYMBOLS = ghnb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ghnb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ghnb_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [ghnb_pkg::SLOT_W-1:0]    m_tuser,
    output logic                          m_tlast,
    input  ghnb_pkg::dp_cmd_t              cmd,
    output ghnb_pkg::dp_status_t           status
);
    import ghnb_pkg::*;

    localparam int CODE_W = 5 * MAX_SYMBOLS;
    localparam int LON_W  = (CODE_W + 1) / 2;
    localparam int LAT_W  = CODE_W / 2;
    localparam int SH_W   = $clog2(CODE_W + 1);
    localparam int NB_W   = 7;

    logic [COORD_W-1:0] lon_code, lat_code;
    logic [LEN_W-1:0]   hash_length;
    logic               len_ok;
    logic [NB_W-1:0]    nbits, nlon, nlat;
    logic [LON_W-1:0]   lon_unit, lon_mask;
    logic [LAT_W-1:0]   lat_unit, lat_mask;

    logic [LON_W-1:0]   lon_reg, lon_unit_reg;
    logic [LAT_W-1:0]   lat_reg, lat_unit_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               ok_reg;
    logic [SH_W-1:0]    rshift_reg;

    step_t              dx, dy;
    logic [LON_W:0]     x_sum, x_dif;
    logic [LAT_W:0]     y_sum, y_dif;
    logic [LON_W-1:0]   x_new;
    logic [LAT_W-1:0]   y_new;
    logic               x_bad, y_bad, cell_ok;
    logic [CODE_W-1:0]  woven, shifted;

    logic                   tvalid_reg;
    logic [CELL_CODE_W-1:0] code_reg;
    logic [LEN_W-1:0]       olen_reg;
    logic                   ovalid_reg;
    logic [SLOT_W-1:0]      oslot_reg;
    logic                   olast_reg;

    assign lon_code    = s_tdata[COORD_W-1:0];
    assign lat_code    = s_tdata[2*COORD_W-1:COORD_W];
    assign hash_length = s_tdata[2*COORD_W+LEN_W-1:2*COORD_W];

    assign len_ok   = (hash_length != '0) && (hash_length <= LEN_W'(MAX_SYMBOLS));
    assign nbits    = {1'b0, hash_length, 2'b00} + NB_W'(hash_length);
    assign nlon     = (nbits + 1'b1) >> 1;
    assign nlat     = nbits >> 1;
    assign lon_unit = LON_W'(1) << (NB_W'(LON_W) - nlon);
    assign lat_unit = LAT_W'(1) << (NB_W'(LAT_W) - nlat);
    assign lon_mask = ~(lon_unit - 1'b1);
    assign lat_mask = ~(lat_unit - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lon_reg      <= lon_code[COORD_W-1 -: LON_W] & lon_mask;
            lat_reg      <= lat_code[COORD_W-1 -: LAT_W] & lat_mask;
            lon_unit_reg <= lon_unit;
            lat_unit_reg <= lat_unit;
            len_reg      <= hash_length;
            ok_reg       <= len_ok;
            rshift_reg   <= SH_W'(NB_W'(CODE_W) - nbits);
        end
    end

    assign dx    = lon_step(cmd.slot);
    assign dy    = lat_step(cmd.slot);
    assign x_sum = {1'b0, lon_reg} + {1'b0, lon_unit_reg};
    assign x_dif = {1'b0, lon_reg} - {1'b0, lon_unit_reg};
    assign y_sum = {1'b0, lat_reg} + {1'b0, lat_unit_reg};
    assign y_dif = {1'b0, lat_reg} - {1'b0, lat_unit_reg};

    always_comb
    begin
        case (dx)
            STEP_INC:
            begin
                x_new = x_sum[LON_W-1:0];
                x_bad = x_sum[LON_W];
            end
            STEP_DEC:
            begin
                x_new = x_dif[LON_W-1:0];
                x_bad = x_dif[LON_W];
            end
            default:
            begin
                x_new = lon_reg;
                x_bad = 1'b0;
            end
        endcase
        case (dy)
            STEP_INC:
            begin
                y_new = y_sum[LAT_W-1:0];
                y_bad = y_sum[LAT_W];
            end
            STEP_DEC:
            begin
                y_new = y_dif[LAT_W-1:0];
                y_bad = y_dif[LAT_W];
            end
            default:
            begin
                y_new = lat_reg;
                y_bad = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        woven = '0;
        for (int i = 0; i < LON_W; i++)
        begin
            woven[CODE_W-1-2*i] = x_new[LON_W-1-i];
        end
        for (int i = 0; i < LAT_W; i++)
        begin
            woven[CODE_W-2-2*i] = y_new[LAT_W-1-i];
        end
    end

    assign shifted = woven >> rshift_reg;
    assign cell_ok = ok_reg && !x_bad && !y_bad;

    assign status.out_free = !tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            code_reg   <= cell_ok ? CELL_CODE_W'(shifted) : '0;
            olen_reg   <= cell_ok ? len_reg : '0;
            ovalid_reg <= cell_ok;
            oslot_reg  <= cmd.slot;
            olast_reg  <= (cmd.slot == SLOT_SW);
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - CELL_CODE_W - LEN_W - 1)'(0), ovalid_reg, olen_reg, code_reg};
    assign m_tuser  = oslot_reg;
    assign m_tlast  = olast_reg;

endmodule

### hw/rtl/geohash_neighbor_grids.sv
// Channel  Dir  Beat contents
// s_       in   tdata: lon_code[31:0], lat_code[63:32], hash_length[67:64]
// m_       out  tdata: cell_code[59:0], cell_length[63:60], cell_valid[64];
//               tuser: cell_slot; tlast: last_cell
//
// Each input beat yields nine output beats, one per cycle when m_tready stays high.
// An input is taken while the controller is idle, and the single neighbor step unit then
// works out its nine cells one after another, center first and the southwest cell last.
// Output stalls hold the sequence; a new input is taken once the ninth cell is registered.
// Reset is asynchronous and active low and clears the controller and output valid.
module geohash_neighbor_grids #(
    parameter int MAX_SYMBOLS = ghnb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // lon_code, lat_code, hash_length, zero pad
    input  logic [ghnb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // cell_code, cell_length, cell_valid, zero pad
    output logic [ghnb_pkg::M_TDATA_W-1:0] m_tdata,
    // cell_slot
    output logic [ghnb_pkg::SLOT_W-1:0]    m_tuser,
    output logic                          m_tlast
);
    import ghnb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ghnb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ghnb_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### hw/rtl/ghnb_checker.sv
module ghnb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ghnb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ghnb_pkg::SLOT_W-1:0]    m_tuser,
    input logic                          m_tlast
);
    import ghnb_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Output beat changed while stalled.");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == SLOT_SW)))
        else $error("Last flag does not match the final slot.");

    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= SLOT_SW))
        else $error("Slot out of range.");

    a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[64] |-> (m_tdata[63:0] == '0))
        else $error("Invalid cell carries a code or length.");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid == 1'b0 || m_tuser == $past(m_tuser) + 1'b1)
        else $error("Cell slots out of order.");

endmodule

bind geohash_neighbor_grids ghnb_checker u_ghnb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/geohash_cell_checker.sv
module geohash_cell_checker
    import ghnb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [SLOT_W-1:0]    m_tuser,
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   cells_pending,
    output int                   cells_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [SLOT_W-1:0]      slot;
        logic [CELL_CODE_W-1:0] code;
        logic [LEN_W-1:0]       length;
        logic                   valid;
        logic                   last;
    } grid_cell_t;

    // Longitude and latitude index steps for each slot, center first.
    const int LON_STEP[9] = '{0, 0, 1, -1, 0, 1, -1, 1, -1};
    const int LAT_STEP[9] = '{0, 1, 0, 0, -1, 1, 1, -1, -1};

    grid_cell_t expected_cells[$];

    task automatic queue_neighbor_cells(input logic [COORD_W-1:0] lon_code,
                                        input logic [COORD_W-1:0] lat_code,
                                        input logic [LEN_W-1:0]   hash_len);
        int         nbits;
        int         nlon;
        int         nlat;
        bit         len_ok;
        longint     lon_idx;
        longint     lat_idx;
        longint     lon_max;
        longint     lat_max;
        longint     x;
        longint     y;
        logic [63:0] xu;
        logic [63:0] yu;
        logic [63:0] woven;
        grid_cell_t c;

        len_ok  = (hash_len >= 1) && (hash_len <= MAX_SYMBOLS_DEF);
        nbits   = 5 * int'(hash_len);
        nlon    = (nbits + 1) / 2;
        nlat    = nbits / 2;
        lon_idx = 0;
        lat_idx = 0;
        lon_max = 0;
        lat_max = 0;
        if (len_ok)
        begin
            lon_idx = longint'({32'd0, lon_code} >> (32 - nlon));
            lat_idx = longint'({32'd0, lat_code} >> (32 - nlat));
            lon_max = longint'((64'd1 << nlon) - 64'd1);
            lat_max = longint'((64'd1 << nlat) - 64'd1);
        end
        for (int s = 0; s < 9; s++)
        begin
            c.slot   = s[SLOT_W-1:0];
            c.last   = (c.slot == SLOT_SW);
            c.code   = '0;
            c.length = '0;
            c.valid  = 1'b0;
            if (len_ok)
            begin
                x = lon_idx + LON_STEP[s];
                y = lat_idx + LAT_STEP[s];
                if (x >= 0 && x <= lon_max && y >= 0 && y <= lat_max)
                begin
                    xu    = x;
                    yu    = y;
                    woven = '0;
                    for (int p = 0; p < nbits; p++)
                    begin
                        if (p % 2 == 0)
                            woven = {woven[62:0], xu[nlon - 1 - p / 2]};
                        else
                            woven = {woven[62:0], yu[nlat - 1 - p / 2]};
                    end
                    c.code   = woven[CELL_CODE_W-1:0];
                    c.length = hash_len;
                    c.valid  = 1'b1;
                end
            end
            expected_cells = {expected_cells, c};
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        grid_cell_t want;
        if (!rst_n)
        begin
            mismatches    = 0;
            cells_pending = 0;
            cells_checked = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_cells.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected cell beat, expected none, actual slot %0d code 0x%0h",
                             $time, m_tuser, m_tdata[CELL_CODE_W-1:0]);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    check_field("cell_slot", 64'(want.slot), 64'(m_tuser));
                    check_field("cell_code", 64'(want.code), 64'(m_tdata[CELL_CODE_W-1:0]));
                    check_field("cell_length", 64'(want.length),
                                64'(m_tdata[CELL_CODE_W+LEN_W-1:CELL_CODE_W]));
                    check_field("cell_valid", 64'(want.valid),
                                64'(m_tdata[CELL_CODE_W+LEN_W]));
                    check_field("last_cell", 64'(want.last), 64'(m_tlast));
                    cells_checked++;
                end
            end
            if (s_tvalid && s_tready)
                queue_neighbor_cells(s_tdata[31:0], s_tdata[63:32], s_tdata[67:64]);
            cells_pending = expected_cells.size();
        end
    end

endmodule

### tb/geohash_neighbor_grids_tb.sv
module geohash_neighbor_grids_tb;

    import ghnb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [SLOT_W-1:0]    m_tuser;
    logic                 m_tlast;

    int mismatches;
    int cells_pending;
    int cells_checked;
    int send_idle_pct = 31;
    int recv_idle_pct = 64;
    int queries_sent = 0;
    int bad_lengths = 0;

    geohash_neighbor_grids dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    geohash_cell_checker cell_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .cells_pending (cells_pending),
        .cells_checked (cells_checked)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_query(input logic [31:0] lon_code, input logic [31:0] lat_code,
                              input logic [3:0] hash_len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'd0, hash_len, lat_code, lon_code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        queries_sent++;
        if (hash_len == 0 || hash_len > MAX_SYMBOLS_DEF)
            bad_lengths++;
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] r;
        case ($urandom_range(5))
            0: r = 32'h0;
            1: r = 32'hFFFF_FFFF;
            2: r = $urandom_range(0, 4095);
            3: r = ~32'($urandom_range(0, 4095));
            default: r = $urandom;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] pick_length();
        logic [3:0] r;
        if ($urandom_range(9) == 0)
        begin
            r = 4'($urandom_range(13, 15));
            if ($urandom_range(3) == 0)
                r = 4'd0;
        end
        else
            r = 4'($urandom_range(1, MAX_SYMBOLS_DEF));
        return r;
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_query(pick_coord(), pick_coord(), pick_length());
    endtask

    task automatic drain_cells();
        s_tvalid = 1'b0;
        while (cells_pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // World corners, saturated codes, and the extreme lengths.
        send_query(32'h0, 32'h0, 4'd1);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1);
        send_query(32'h0, 32'hFFFF_FFFF, 4'd12);
        send_query(32'hFFFF_FFFF, 32'h0, 4'd12);
        send_query(32'h0, 32'h0, 4'd12);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd12);
        send_query(32'h8000_0000, 32'h8000_0000, 4'd5);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 4'd7);
        send_query(32'h5555_5555, 32'hAAAA_AAAA, 4'd12);
        send_query(32'hAAAA_AAAA, 32'h5555_5555, 4'd11);
        // Bad lengths still give nine beats, all invalid.
        send_query($urandom, $urandom, 4'd0);
        send_query($urandom, $urandom, 4'd13);
        send_query($urandom, $urandom, 4'd15);
        for (int len = 2; len <= 11; len++)
            send_query($urandom, $urandom, len[3:0]);
        send_random(20);
        drain_cells();

        send_idle_pct = 64;
        recv_idle_pct = 31;
        send_random(35);
        drain_cells();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(52);
        drain_cells();
        repeat (20) @(negedge clk);

        $display("Ran %0d queries (%0d with a bad length) and compared %0d cell beats",
                 queries_sent, bad_lengths, cells_checked);
        $display("across world edges, corners and lengths 0 to 15 under three stall mixes.");
        if (mismatches == 0 && cells_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ghnb_pkg.sv
hw/rtl/ghnb_ctrl.sv
hw/rtl/ghnb_dp.sv
hw/rtl/geohash_neighbor_grids.sv
hw/rtl/ghnb_checker.sv
tb/geohash_cell_checker.sv
tb/geohash_neighbor_grids_tb.sv
